FILE: rtl/core/assert_macros.svh
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/napt_hr_pkg.sv
package napt_hr_pkg;

  localparam logic [1:0] OP_HDR  = 2'd0;
  localparam logic [1:0] OP_INS  = 2'd1;
  localparam logic [1:0] OP_REM  = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam logic [1:0] SH_OK  = 2'd0;
  localparam logic [1:0] SH_ETH = 2'd1;
  localparam logic [1:0] SH_IP  = 2'd2;
  localparam logic [1:0] SH_TCP = 2'd3;

  localparam logic [15:0] IPV4_ETHERTYPE = 16'h0800;
  localparam logic [7:0]  TCP_PROTO_NUM  = 8'd6;

  localparam logic [2:0] ST_PASS    = 3'd0;
  localparam logic [2:0] ST_DROP    = 3'd1;
  localparam logic [2:0] ST_XLATE   = 3'd2;
  localparam logic [2:0] ST_WRITTEN = 3'd3;
  localparam logic [2:0] ST_REMOVED = 3'd4;
  localparam logic [2:0] ST_FULL    = 3'd5;
  localparam logic [2:0] ST_RMISS   = 3'd6;

  // One table entry: valid, key endpoint, translated endpoint
  typedef struct packed {
    logic        vld;
    logic [47:0] key;
    logic [47:0] val;
  } ent_t;

  // One's-complement fold of a wide sum down to 16 bits
  function automatic logic [15:0] fold16(input logic [35:0] s);
    logic [20:0] f1;
    logic [16:0] f2;
    logic [16:0] f3;
    f1 = {5'd0, s[15:0]} + {1'b0, s[35:16]};
    f2 = {1'b0, f1[15:0]} + {12'd0, f1[20:16]};
    f3 = {1'b0, f2[15:0]} + {16'd0, f2[16]};
    return f3[15:0];
  endfunction

endpackage

FILE: rtl/core/napt_header_rewrite_core.sv
// NAPT header rewrite core. One word is taken at a time. A pass/drop decision
// or an unused op shows its result word the cycle after acceptance. A table
// lookup or command scans the selected table, one entry per cycle through the
// read port of the table memory, then passes through S_DONE to S_OUT, where
// its result word shows. A result word is held until out_ready. After reset
// both tables in the table memory are cleared, during which in_ready stays
// low.
`include "assert_macros.svh"

module napt_header_rewrite_core #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic        in_direction,
  input  logic [1:0]  in_short_header,
  input  logic [15:0] in_eth_type,
  input  logic [7:0]  in_version_ihl,
  input  logic [7:0]  in_protocol,
  input  logic [31:0] in_src_addr,
  input  logic [31:0] in_dst_addr,
  input  logic [15:0] in_src_port,
  input  logic [15:0] in_dst_port,
  input  logic [15:0] in_ip_checksum,
  input  logic [15:0] in_tcp_checksum,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_new_src_addr,
  output logic [31:0] out_new_dst_addr,
  output logic [15:0] out_new_src_port,
  output logic [15:0] out_new_dst_port,
  output logic [15:0] out_new_ip_checksum,
  output logic [15:0] out_new_tcp_checksum
);

  localparam int IW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int AW    = IW + 1;
  localparam int DEPTH = 2 ** AW;
  localparam logic [AW-1:0] LAST_N = AW'(TABLE_ENTRIES);
  localparam logic [AW-1:0] LAST_A = {AW{1'b1}};

  typedef enum logic [4:0] {
    S_CLR  = 5'b00001,
    S_IDLE = 5'b00010,
    S_SCAN = 5'b00100,
    S_DONE = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Table memory: both tables, direction selects the upper half
  napt_hr_pkg::ent_t mem [DEPTH];
  napt_hr_pkg::ent_t rdata_r;
  logic              we;
  logic [AW-1:0]     wa, ra;
  napt_hr_pkg::ent_t wd;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_r <= mem[ra];
  end

  // Latched word
  logic [1:0]  op_r;
  logic        dir_r;
  logic [31:0] sa_r, da_r;
  logic [15:0] sp_r, dp_r, ipc_r, tcpc_r;
  logic [47:0] key_r;

  // Scan control and findings
  logic [AW-1:0] cnt_r;
  logic          rvld_r;
  logic [IW-1:0] chk_r;
  logic          hit_r, free_r;
  logic [IW-1:0] hit_idx_r, free_idx_r;
  logic [47:0]   hit_val_r;

  // Result register
  logic [2:0]  st_r;
  logic [31:0] osa_r, oda_r;
  logic [15:0] osp_r, odp_r, oipc_r, otcpc_r;

  logic in_fire, out_fire;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  // Header checks on the incoming word
  logic       hdr_lookup;
  logic [2:0] hdr_st;
  always_comb begin
    hdr_lookup = 1'b0;
    hdr_st     = napt_hr_pkg::ST_PASS;
    if (in_short_header == napt_hr_pkg::SH_ETH) begin
      hdr_st = napt_hr_pkg::ST_DROP;
    end else if (in_eth_type != napt_hr_pkg::IPV4_ETHERTYPE) begin
      hdr_st = napt_hr_pkg::ST_PASS;
    end else if (in_short_header == napt_hr_pkg::SH_IP) begin
      hdr_st = napt_hr_pkg::ST_DROP;
    end else if (in_protocol != napt_hr_pkg::TCP_PROTO_NUM) begin
      hdr_st = napt_hr_pkg::ST_PASS;
    end else if (in_version_ihl[7:4] != 4'd4) begin
      hdr_st = napt_hr_pkg::ST_DROP;
    end else if (in_version_ihl[3:0] != 4'd5) begin
      hdr_st = napt_hr_pkg::ST_PASS;
    end else if (in_short_header == napt_hr_pkg::SH_TCP) begin
      hdr_st = napt_hr_pkg::ST_DROP;
    end else begin
      hdr_lookup = 1'b1;
    end
  end

  logic is_cmd;
  assign is_cmd = (in_op == napt_hr_pkg::OP_INS) || (in_op == napt_hr_pkg::OP_REM);

  // Checksum update from the hit value
  logic [31:0] old_a, new_a;
  logic [15:0] old_p, new_p;
  logic [32:0] l3;
  logic [33:0] l4;
  logic [15:0] ip_new, tcp_new;
  always_comb begin
    old_a  = dir_r ? sa_r : da_r;
    old_p  = dir_r ? sp_r : dp_r;
    new_a  = hit_val_r[47:16];
    new_p  = hit_val_r[15:0];
    l3     = {1'b0, ~old_a} + {1'b0, new_a};
    l4     = {18'd0, ~old_p} + {18'd0, new_p} + {1'b0, l3};
    ip_new = ~napt_hr_pkg::fold16({3'd0, l3} + {20'd0, ~ipc_r});
    tcp_new = ~napt_hr_pkg::fold16({2'd0, l4} + {20'd0, ~tcpc_r});
  end

  // Memory port control
  always_comb begin
    we = 1'b0;
    wa = cnt_r;
    wd = '0;
    ra = {dir_r, cnt_r[IW-1:0]};
    if (state_r == S_CLR) begin
      we = 1'b1;
    end else if (state_r == S_DONE) begin
      wd.vld = 1'b1;
      wd.key = key_r;
      wd.val = {da_r, dp_r};
      if (op_r == napt_hr_pkg::OP_INS) begin
        we = hit_r || free_r;
        wa = {dir_r, hit_r ? hit_idx_r : free_idx_r};
      end else if (op_r == napt_hr_pkg::OP_REM) begin
        we = hit_r;
        wa = {dir_r, hit_idx_r};
        wd = '0;
      end
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR:  if (cnt_r == LAST_A) state_nxt = S_IDLE;
      S_IDLE: if (in_fire) state_nxt = ((in_op == napt_hr_pkg::OP_HDR && hdr_lookup)
                                        || is_cmd) ? S_SCAN : S_OUT;
      S_SCAN: if (cnt_r == LAST_N && !rvld_r) state_nxt = S_DONE;
      S_DONE: state_nxt = S_OUT;
      S_OUT:  if (out_fire) state_nxt = S_IDLE;
      default: state_nxt = S_CLR;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      cnt_r   <= '0;
      rvld_r  <= 1'b0;
      hit_r   <= 1'b0;
      free_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_CLR: begin
          cnt_r <= cnt_r + 1'b1;
        end
        S_IDLE: begin
          cnt_r  <= '0;
          rvld_r <= 1'b0;
          hit_r  <= 1'b0;
          free_r <= 1'b0;
        end
        S_SCAN: begin
          rvld_r <= (cnt_r != LAST_N);
          if (cnt_r != LAST_N) cnt_r <= cnt_r + 1'b1;
          if (rvld_r) begin
            if (rdata_r.vld && rdata_r.key == key_r && !hit_r) hit_r <= 1'b1;
            if (!rdata_r.vld && !free_r) free_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    chk_r <= cnt_r[IW-1:0];
    if (state_r == S_SCAN && rvld_r) begin
      if (rdata_r.vld && rdata_r.key == key_r && !hit_r) begin
        hit_idx_r <= chk_r;
        hit_val_r <= rdata_r.val;
      end
      if (!rdata_r.vld && !free_r) free_idx_r <= chk_r;
    end
    if (in_fire) begin
      op_r   <= in_op;
      dir_r  <= in_direction;
      sa_r   <= in_src_addr;
      da_r   <= in_dst_addr;
      sp_r   <= in_src_port;
      dp_r   <= in_dst_port;
      ipc_r  <= in_ip_checksum;
      tcpc_r <= in_tcp_checksum;
      if (is_cmd || in_direction) key_r <= {in_src_addr, in_src_port};
      else key_r <= {in_dst_addr, in_dst_port};
      // header words carry through, everything else reads zero
      osa_r   <= (in_op == napt_hr_pkg::OP_HDR) ? in_src_addr : '0;
      oda_r   <= (in_op == napt_hr_pkg::OP_HDR) ? in_dst_addr : '0;
      osp_r   <= (in_op == napt_hr_pkg::OP_HDR) ? in_src_port : '0;
      odp_r   <= (in_op == napt_hr_pkg::OP_HDR) ? in_dst_port : '0;
      oipc_r  <= (in_op == napt_hr_pkg::OP_HDR) ? in_ip_checksum : '0;
      otcpc_r <= (in_op == napt_hr_pkg::OP_HDR) ? in_tcp_checksum : '0;
      st_r    <= (in_op == napt_hr_pkg::OP_HDR) ? hdr_st : napt_hr_pkg::ST_PASS;
    end else if (state_r == S_DONE) begin
      if (op_r == napt_hr_pkg::OP_INS) begin
        st_r <= (hit_r || free_r) ? napt_hr_pkg::ST_WRITTEN : napt_hr_pkg::ST_FULL;
      end else if (op_r == napt_hr_pkg::OP_REM) begin
        st_r <= hit_r ? napt_hr_pkg::ST_REMOVED : napt_hr_pkg::ST_RMISS;
      end else if (hit_r) begin
        st_r    <= napt_hr_pkg::ST_XLATE;
        oipc_r  <= ip_new;
        otcpc_r <= tcp_new;
        if (dir_r) begin
          osa_r <= new_a;
          osp_r <= new_p;
        end else begin
          oda_r <= new_a;
          odp_r <= new_p;
        end
      end
    end
  end

  assign out_status           = st_r;
  assign out_new_src_addr     = osa_r;
  assign out_new_dst_addr     = oda_r;
  assign out_new_src_port     = osp_r;
  assign out_new_dst_port     = odp_r;
  assign out_new_ip_checksum  = oipc_r;
  assign out_new_tcp_checksum = otcpc_r;

  // Checks
  `ASSERT_IMP(a_no_write_in_scan, clk, rst_n, state_r == S_SCAN, !we)
  `ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_fire, state_r == S_SCAN || state_r == S_OUT)
  `ASSERT_NEXT(a_done_to_out, clk, rst_n, state_r == S_DONE, out_valid)
  `ASSERT_IMP(a_scan_count, clk, rst_n, state_r == S_SCAN, cnt_r <= LAST_N)

endmodule
